// File: rtl/bso_pkg.sv
// ----------------------------------------------------------------------------
// bso_pkg
// shared types, codes and the logo bitmap for the bouncing sprite overlay
// ----------------------------------------------------------------------------
`default_nettype none

package bso_pkg;

  localparam int unsigned PosW      = 7;
  localparam int unsigned LogoW     = 44;
  localparam int unsigned LogoH     = 24;
  localparam int unsigned LogoPages = 3;
  localparam int unsigned ColIdxW   = 6;
  localparam int unsigned PageIdxW  = 2;

  localparam logic [PosW-1:0] StartX = 7'd9;
  localparam logic [PosW-1:0] StartY = 7'd16;

  typedef enum logic [0:0] {
    FuncTick = 1'b0,
    FuncScan = 1'b1
  } func_e;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } pos_t;

  localparam logic [7:0] LogoRom [LogoPages][LogoW] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'hfc, 8'hfc, 8'h0c, 8'h0c,
      8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'hf0, 8'hf0, 8'h00, 8'h00,
      8'h00, 8'hfc, 8'hfc, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hfc, 8'hfc, 8'h00, 8'h00, 8'h00, 8'hfc, 8'hfc,
      8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'hf0, 8'hf0,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hc0, 8'hc0,
      8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'h3f, 8'h3f, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h0f, 8'h0f, 8'hf0, 8'hf0, 8'h0f,
      8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff,
      8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'h3f, 8'h3f,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h08, 8'h1c, 8'h1c, 8'h1c, 8'h1c, 8'h3e, 8'h3e, 8'h3e,
      8'h3e, 8'h3e, 8'h3e, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h7f, 8'h3e, 8'h3e, 8'h3e, 8'h3e, 8'h3e, 8'h3e, 8'h1c,
      8'h1c, 8'h1c, 8'h1c, 8'h08}
  };

  // logo byte, zero outside the bitmap
  function automatic logic [7:0] logo_byte(input logic [PageIdxW-1:0] pg,
                                           input logic [ColIdxW-1:0] col);
    logic [7:0] b;
    b = 8'h00;
    if (32'(pg) < LogoPages && 32'(col) < LogoW) begin
      b = LogoRom[pg][col];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bso_motion.sv
// ----------------------------------------------------------------------------
// bso_motion
// logo position and direction registers with the bounce step
// ----------------------------------------------------------------------------
`default_nettype none

module bso_motion #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_ROWS    = 128
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              step_i,
  output bso_pkg::pos_t    pos_o,
  output bso_pkg::pos_t    pos_next_o
);

  localparam logic [bso_pkg::PosW-1:0] LimitX =
    bso_pkg::PosW'(SCREEN_COLUMNS - bso_pkg::LogoW);
  localparam logic [bso_pkg::PosW-1:0] LimitY =
    bso_pkg::PosW'(SCREEN_ROWS - bso_pkg::LogoH);

  bso_pkg::pos_t pos_q, pos_d;
  logic          right_q, right_d;
  logic          down_q, down_d;

  always_comb begin
    pos_d   = pos_q;
    right_d = right_q;
    down_d  = down_q;
    // x axis
    if (right_q) begin
      if (pos_q.x < LimitX) begin
        pos_d.x = pos_q.x + 1'b1;
      end else begin
        right_d = 1'b0;
        pos_d.x = pos_q.x - 1'b1;
      end
    end else if (pos_q.x != '0) begin
      pos_d.x = pos_q.x - 1'b1;
    end else begin
      right_d = 1'b1;
      pos_d.x = pos_q.x + 1'b1;
    end
    // y axis, a start row past the limit turns back on the first tick
    if (down_q) begin
      if (pos_q.y < LimitY) begin
        pos_d.y = pos_q.y + 1'b1;
      end else begin
        down_d  = 1'b0;
        pos_d.y = pos_q.y - 1'b1;
      end
    end else if (pos_q.y != '0) begin
      pos_d.y = pos_q.y - 1'b1;
    end else begin
      down_d  = 1'b1;
      pos_d.y = pos_q.y + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q.x <= bso_pkg::StartX;
      pos_q.y <= bso_pkg::StartY;
      right_q <= 1'b1;
      down_q  <= 1'b1;
    end else if (step_i) begin
      pos_q   <= pos_d;
      right_q <= right_d;
      down_q  <= down_d;
    end
  end

  assign pos_o      = pos_q;
  assign pos_next_o = pos_d;

endmodule

`default_nettype wire

// File: rtl/bso_overlay.sv
// ----------------------------------------------------------------------------
// bso_overlay
// merges the logo bits of one display byte onto the background byte
// ----------------------------------------------------------------------------
`default_nettype none

module bso_overlay (
  input  bso_pkg::pos_t pos_i,
  input  wire [3:0]     page_i,
  input  wire [6:0]     column_i,
  input  wire [7:0]     background_i,
  output logic [7:0]    pixel_byte_o
);

  logic [3:0]                     top_page;
  logic [2:0]                     shift;
  logic [7:0]                     col_end;
  logic                           in_cols;
  logic [6:0]                     col_diff;
  logic [bso_pkg::ColIdxW-1:0]    col;
  logic [3:0]                     rel;
  logic [3:0]                     rel_m1;
  logic [7:0]                     lo_byte;
  logic [7:0]                     hi_byte;
  logic [15:0]                    merged;

  always_comb begin
    top_page = pos_i.y[6:3];
    shift    = pos_i.y[2:0];
    col_end  = {1'b0, pos_i.x} + 8'(bso_pkg::LogoW);
    in_cols  = (column_i >= pos_i.x) && ({1'b0, column_i} < col_end);
    col_diff = column_i - pos_i.x;
    col      = col_diff[bso_pkg::ColIdxW-1:0];
    rel      = page_i - top_page;
    rel_m1   = rel - 4'd1;
    // current logo page lands shifted down, the page above spills in
    lo_byte  = (rel < 4'(bso_pkg::LogoPages)) ?
               bso_pkg::logo_byte(rel[1:0], col) : 8'h00;
    hi_byte  = (rel != 4'd0 && rel_m1 < 4'(bso_pkg::LogoPages)) ?
               bso_pkg::logo_byte(rel_m1[1:0], col) : 8'h00;
    merged   = {lo_byte, hi_byte} << shift;
    if (in_cols && page_i >= top_page) begin
      pixel_byte_o = background_i | merged[15:8];
    end else begin
      pixel_byte_o = background_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bouncing_sprite_overlay_top.sv
// ----------------------------------------------------------------------------
// bouncing_sprite_overlay_top
// bouncing 44x24 logo overlaid on a page-organised monochrome display
// ----------------------------------------------------------------------------
//
//  channel | handshake                | word
//  --------+--------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o  | func_i, page_i, column_i, background_i
//  out     | out_valid_o / out_ready_i| pixel_byte_o, pos_x_o, pos_y_o
//
//  two register stages: input register, then result register; one word in
//  and one word out per cycle when the output is not stalled
//  result is registered in the result register once its word leaves the input register
//  a frame tick moves the logo when it passes from input register to result
//  reset puts the logo at column 9, row 16, moving right and down
//  a stalled output holds the result register and backs up the input stage
//
`default_nettype none

module bouncing_sprite_overlay_top #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_ROWS    = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input words
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [0:0]  func_i,
  input  wire  [3:0]  page_i,
  input  wire  [6:0]  column_i,
  input  wire  [7:0]  background_i,
  // result words
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  pixel_byte_o,
  output logic [6:0]  pos_x_o,
  output logic [6:0]  pos_y_o
);

  // input register
  logic                s1_valid_q;
  bso_pkg::func_e      s1_func_q;
  logic [3:0]          s1_page_q;
  logic [6:0]          s1_column_q;
  logic [7:0]          s1_background_q;

  // result register
  logic                out_valid_q;
  logic [7:0]          pixel_byte_q, pixel_byte_d;
  bso_pkg::pos_t       out_pos_q, out_pos_d;

  logic                advance;
  logic                s1_fire;
  logic                tick;
  bso_pkg::pos_t       pos_cur;
  bso_pkg::pos_t       pos_next;
  logic [7:0]          overlay_byte;

  // result register frees up when empty or being taken this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign s1_fire    = s1_valid_q && advance;
  assign tick       = s1_fire && (s1_func_q == bso_pkg::FuncTick);

  bso_motion #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_motion (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (tick),
    .pos_o      (pos_cur),
    .pos_next_o (pos_next)
  );

  bso_overlay u_overlay (
    .pos_i        (pos_cur),
    .page_i       (s1_page_q),
    .column_i     (s1_column_q),
    .background_i (s1_background_q),
    .pixel_byte_o (overlay_byte)
  );

  // frame tick reports the new position and a zero byte
  always_comb begin
    if (s1_func_q == bso_pkg::FuncTick) begin
      pixel_byte_d = 8'h00;
      out_pos_d    = pos_next;
    end else begin
      pixel_byte_d = overlay_byte;
      out_pos_d    = pos_cur;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_func_q       <= bso_pkg::func_e'(func_i);
      s1_page_q       <= page_i;
      s1_column_q     <= column_i;
      s1_background_q <= background_i;
    end
    if (s1_fire) begin
      pixel_byte_q <= pixel_byte_d;
      out_pos_q    <= out_pos_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pixel_byte_q;
  assign pos_x_o      = out_pos_q.x;
  assign pos_y_o      = out_pos_q.y;

endmodule

`default_nettype wire

// File: tb/bso_overlay_checker.sv
// ----------------------------------------------------------------------------
// bso_overlay_checker
// watches both channels of the sprite overlay, predicts each result word from
// its own copy of the logo position and bitmap, and compares in order
// ----------------------------------------------------------------------------

module bso_overlay_checker #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_ROWS    = 128
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  wire  [0:0] func_i,
  input  wire  [3:0] page_i,
  input  wire  [6:0] column_i,
  input  wire  [7:0] background_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  wire  [7:0] pixel_byte_i,
  input  wire  [6:0] pos_x_i,
  input  wire  [6:0] pos_y_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LimitX = SCREEN_COLUMNS - bso_pkg::LogoW;
  localparam int unsigned LimitY = SCREEN_ROWS - bso_pkg::LogoH;

  // logo bitmap, one byte per column, bit n is row n of the page
  localparam logic [7:0] LogoBitmap [3][44] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'hfc, 8'hfc, 8'h0c, 8'h0c,
      8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'hf0, 8'hf0, 8'h00, 8'h00,
      8'h00, 8'hfc, 8'hfc, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hfc, 8'hfc, 8'h00, 8'h00, 8'h00, 8'hfc, 8'hfc,
      8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'h0c, 8'hf0, 8'hf0,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hc0, 8'hc0,
      8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'h3f, 8'h3f, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h0f, 8'h0f, 8'hf0, 8'hf0, 8'h0f,
      8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff,
      8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'hc0, 8'h3f, 8'h3f,
      8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h08, 8'h1c, 8'h1c, 8'h1c, 8'h1c, 8'h3e, 8'h3e, 8'h3e,
      8'h3e, 8'h3e, 8'h3e, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h7f, 8'h3e, 8'h3e, 8'h3e, 8'h3e, 8'h3e, 8'h3e, 8'h1c,
      8'h1c, 8'h1c, 8'h1c, 8'h08}
  };

  typedef struct packed {
    logic [7:0] pixel;
    logic [6:0] x;
    logic [6:0] y;
  } overlay_word_t;

  overlay_word_t expected_words[$];

  logic [6:0] logo_col;
  logic [6:0] logo_row;
  logic       heading_right;
  logic       heading_down;
  int         mismatches;
  int         words_seen;

  // one bounce step on one axis, returns {direction, position}
  function automatic logic [7:0] bounce_step(input logic [6:0] pos, input logic fwd,
                                             input int unsigned limit);
    logic [6:0] p;
    logic       f;
    p = pos;
    f = fwd;
    if (f) begin
      if (32'(pos) < limit) begin
        p = pos + 7'd1;
      end else begin
        f = 1'b0;
        p = pos - 7'd1;
      end
    end else if (pos != 7'd0) begin
      p = pos - 7'd1;
    end else begin
      f = 1'b1;
      p = pos + 7'd1;
    end
    return {f, p};
  endfunction

  // background ORed with the logo bits that land in this display byte
  function automatic logic [7:0] overlaid_byte(input logic [3:0] pg, input logic [6:0] col,
                                               input logic [7:0] bg, input logic [6:0] lx,
                                               input logic [6:0] ly);
    int unsigned top_page;
    int unsigned shift;
    int unsigned rel;
    int unsigned c;
    logic [15:0] wide;
    logic [7:0]  bits;
    top_page = 32'(ly) >> 3;
    shift    = 32'(ly) & 7;
    if (col < lx || 32'(col) >= 32'(lx) + bso_pkg::LogoW) return bg;
    c = 32'(col) - 32'(lx);
    if (32'(pg) < top_page) return bg;
    rel  = 32'(pg) - top_page;
    bits = 8'h00;
    if (rel < bso_pkg::LogoPages) begin
      wide = {8'h00, LogoBitmap[rel][c]} << shift;
      bits = bits | wide[7:0];
    end
    // spill from the page above when the logo is not page aligned
    if (shift != 0 && rel >= 1 && rel - 1 < bso_pkg::LogoPages) begin
      bits = bits | (LogoBitmap[rel-1][c] >> (8 - shift));
    end
    return bg | bits;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    overlay_word_t got;
    overlay_word_t want;
    logic [7:0]    axis;
    if (!rst_ni) begin
      logo_col      = bso_pkg::StartX;
      logo_row      = bso_pkg::StartY;
      heading_right = 1'b1;
      heading_down  = 1'b1;
      mismatches    = 0;
      words_seen    = 0;
      expected_words.delete();
    end else begin
      // results first: a word accepted now cannot belong to this cycle's input
      if (out_valid_i && out_ready_i) begin
        got = '{pixel: pixel_byte_i, x: pos_x_i, y: pos_y_i};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word %0d with nothing expected: pixel %02h x %0d y %0d",
                     $realtime, words_seen, got.pixel, got.x, got.y);
          end
        end else begin
          want = expected_words.pop_front();
          if (got.pixel !== want.pixel || got.x !== want.x || got.y !== want.y) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word %0d expected pixel %02h x %0d y %0d, got pixel %02h x %0d y %0d",
                       $realtime, words_seen, want.pixel, want.x, want.y,
                       got.pixel, got.x, got.y);
            end
          end
        end
        words_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == bso_pkg::FuncTick) begin
          axis          = bounce_step(logo_col, heading_right, LimitX);
          logo_col      = axis[6:0];
          heading_right = axis[7];
          axis          = bounce_step(logo_row, heading_down, LimitY);
          logo_row      = axis[6:0];
          heading_down  = axis[7];
          want.pixel    = 8'h00;
        end else begin
          want.pixel = overlaid_byte(page_i, column_i, background_i, logo_col, logo_row);
        end
        want.x = logo_col;
        want.y = logo_row;
        expected_words.push_back(want);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_words.size();
  end

endmodule

// File: tb/tb_bouncing_sprite_overlay_top.sv
// ----------------------------------------------------------------------------
// tb_bouncing_sprite_overlay_top
// drives frame ticks and scan bytes into the sprite overlay with random gaps
// and output stalls; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------

module tb_bouncing_sprite_overlay_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Columns     = 128;
  localparam int unsigned Rows        = 128;
  localparam int          RandomWords = 500;
  // stretch of the random part with no gaps and no stalls at all
  localparam int          SteadyFirst = 200;
  localparam int          SteadyLast  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [0:0]  func;
  logic [3:0]  page;
  logic [6:0]  column;
  logic [7:0]  background;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_byte;
  logic [6:0]  pos_x;
  logic [6:0]  pos_y;
  logic        steady_run = 1'b0;
  // last logo position seen on the output, used only to aim scan bytes
  logic [6:0]  aim_x = bso_pkg::StartX;
  logic [6:0]  aim_y = bso_pkg::StartY;
  int          mismatch_count;
  int          words_pending;

  bouncing_sprite_overlay_top #(
    .SCREEN_COLUMNS(Columns),
    .SCREEN_ROWS   (Rows)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .page_i      (page),
    .column_i    (column),
    .background_i(background),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_byte_o(pixel_byte),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y)
  );

  bso_overlay_checker #(
    .SCREEN_COLUMNS(Columns),
    .SCREEN_ROWS   (Rows)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .func_i          (func),
    .page_i          (page),
    .column_i        (column),
    .background_i    (background),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_byte_i    (pixel_byte),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .mismatch_count_o(mismatch_count),
    .pending_o       (words_pending)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls about a third of the cycles, never during the steady stretch
  always @(posedge clk_i) begin
    out_ready <= steady_run || ($urandom_range(99) >= 34);
  end

  // follow the logo so that most scan bytes land on or next to it
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      aim_x <= pos_x;
      aim_y <= pos_y;
    end
  end

  // generous bound on the whole run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // one word on the input channel: optional idle cycles, then hold until taken;
  // returns at the edge that accepted the word
  task automatic send_word(input bso_pkg::func_e fn, input logic [3:0] pg,
                           input logic [6:0] col, input logic [7:0] bg,
                           input logic no_gaps);
    while (!no_gaps && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    page       <= pg;
    column     <= col;
    background <= bg;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  initial begin
    bso_pkg::func_e fn;
    logic [3:0]     pg;
    logic [6:0]     col;
    logic [7:0]     bg;
    int             drain_cycles;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    func       = bso_pkg::FuncTick;
    page       = 4'd0;
    column     = 7'd0;
    background = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: logo at column 9, row 16, page aligned
    send_word(bso_pkg::FuncScan, 4'd2, 7'd9, 8'h00, 1'b0);    // first logo column
    send_word(bso_pkg::FuncScan, 4'd2, 7'd13, 8'hff, 1'b0);   // full background
    send_word(bso_pkg::FuncScan, 4'd4, 7'd52, 8'h5a, 1'b0);   // last logo column
    send_word(bso_pkg::FuncScan, 4'd4, 7'd53, 8'h00, 1'b0);   // just right of logo
    send_word(bso_pkg::FuncScan, 4'd2, 7'd8, 8'h81, 1'b0);    // just left of logo
    send_word(bso_pkg::FuncScan, 4'd1, 7'd20, 8'h3c, 1'b0);   // page above logo
    send_word(bso_pkg::FuncScan, 4'd5, 7'd20, 8'h00, 1'b0);   // page below, no spill
    send_word(bso_pkg::FuncScan, 4'd15, 7'd127, 8'hff, 1'b0); // far corner
    send_word(bso_pkg::FuncScan, 4'd0, 7'd0, 8'h00, 1'b0);    // origin
    // one tick: row 17, logo bits shifted by one with spill
    send_word(bso_pkg::FuncTick, 4'd15, 7'd127, 8'hff, 1'b0);
    send_word(bso_pkg::FuncScan, 4'd4, 7'd30, 8'h00, 1'b0);
    send_word(bso_pkg::FuncScan, 4'd5, 7'd30, 8'h00, 1'b0);   // spill into next page
    send_word(bso_pkg::FuncScan, 4'd2, 7'd10, 8'h00, 1'b0);
    // six more ticks: row 23, largest shift
    repeat (6) send_word(bso_pkg::FuncTick, 4'd0, 7'd0, 8'h00, 1'b0);
    send_word(bso_pkg::FuncScan, 4'd5, 7'd40, 8'h00, 1'b0);
    send_word(bso_pkg::FuncScan, 4'd3, 7'd20, 8'hf0, 1'b0);
    send_word(bso_pkg::FuncScan, 4'd2, 7'd16, 8'h00, 1'b0);

    // random: half ticks so the logo reaches every wall, scans mostly aimed
    for (int i = 0; i < RandomWords; i++) begin
      steady_run <= (i >= SteadyFirst && i < SteadyLast);
      fn = ($urandom_range(1) == 0) ? bso_pkg::FuncTick : bso_pkg::FuncScan;
      if (fn == bso_pkg::FuncScan && $urandom_range(99) < 80) begin
        col = aim_x + 7'($urandom_range(47)) - 7'd2;
        pg  = 4'(aim_y >> 3) + 4'($urandom_range(4)) - 4'd1;
      end else begin
        col = 7'($urandom);
        pg  = 4'($urandom);
      end
      // a clear background shows the logo bits on their own
      bg = ($urandom_range(99) < 30) ? 8'h00 : 8'($urandom);
      send_word(fn, pg, col, bg, (i >= SteadyFirst && i < SteadyLast));
    end
    in_valid   <= 1'b0;
    steady_run <= 1'b0;

    // drain: let the pipeline empty, then keep watching for stray words
    drain_cycles = 0;
    repeat (2) @(posedge clk_i);
    while (words_pending != 0 && drain_cycles < 10000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
